// ===== design/tlta_pkg.sv =====
// ----------------------------------------------------------------------------
// tlta_pkg
// shared types and constants of the toolpath length and time accumulator
// ----------------------------------------------------------------------------
package tlta_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int TOTAL_BITS_DEF = 48;
    localparam int RAPID_FEED_DEF = 10000000;

    localparam int REG_BITS = 27;
    localparam int IDX_BITS = 1;
    localparam int SEG_BITS = 33;
    localparam int OUT_BITS = 48;
    localparam int OVR_BITS = 16;
    localparam int KIND_BITS = 3;

    // 60000000 * 256
    localparam longint unsigned TIME_SCALE = 64'd15360000000;
    localparam int SCALE_BITS = 34;
    localparam int DEN_BITS = 44;
    localparam int NUM_BITS = SEG_BITS + SCALE_BITS;

    localparam logic [REG_BITS-1:0] CUT_FEED_RST = 27'd1000000;
    localparam logic [REG_BITS-1:0] PLUNGE_FEED_RST = 27'd300000;

    typedef enum logic [IDX_BITS-1:0] {
        REG_CUTTING_FEED = 1'b0,
        REG_PLUNGE_FEED  = 1'b1
    } reg_idx_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_RAPID     = 3'd0,
        KIND_LINEAR    = 3'd1,
        KIND_ARC_CW    = 3'd2,
        KIND_ARC_CCW   = 3'd3,
        KIND_MICROLIFT = 3'd4,
        KIND_RETRACT   = 3'd5,
        KIND_PLUNGE    = 3'd6,
        KIND_OTHER     = 3'd7
    } motion_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

// ===== design/tlta_if.sv =====
// ----------------------------------------------------------------------------
// tlta_pt_if / tlta_res_if
// valid/ready channels for toolpath points and results
// ----------------------------------------------------------------------------
interface tlta_pt_if;
    logic                                valid;
    logic                                ready;
    logic                                first_point;
    logic signed [31:0]                  pos_x;
    logic signed [31:0]                  pos_y;
    logic signed [31:0]                  pos_z;
    logic [tlta_pkg::KIND_BITS-1:0]      motion_kind;
    logic [tlta_pkg::OVR_BITS-1:0]       feed_override;

    modport source (output valid, first_point, pos_x, pos_y, pos_z, motion_kind,
                    feed_override, input ready);
    modport sink   (input valid, first_point, pos_x, pos_y, pos_z, motion_kind,
                    feed_override, output ready);
endinterface

interface tlta_res_if;
    logic                               valid;
    logic                               ready;
    logic [tlta_pkg::SEG_BITS-1:0]      segment_length;
    logic [tlta_pkg::OUT_BITS-1:0]      path_length;
    logic [tlta_pkg::OUT_BITS-1:0]      path_time;

    modport source (output valid, segment_length, path_length, path_time,
                    input ready);
    modport sink   (input valid, segment_length, path_length, path_time,
                    output ready);
endinterface

// ===== design/toolpath_length_time_accumulator.sv =====
// ----------------------------------------------------------------------------
// toolpath_length_time_accumulator
// segment length, path length and travel time of a toolpath
// ----------------------------------------------------------------------------
// Each point transfer is classified by the front stage (coordinate deltas to
// the previous point, feed denominator by motion kind) into a one-entry queue.
// The back stage squares the deltas, takes a bitwise square root, scales by
// 60e6*256 and, for a nonzero denominator, runs a restoring divide of one
// quotient bit per cycle. A first point, or one with no previous point, skips
// these steps. The result register is the back stage's output; a new point
// enters while the result waits.
module toolpath_length_time_accumulator #(
    parameter int COORD_BITS = tlta_pkg::COORD_BITS_DEF,
    parameter int TOTAL_BITS = tlta_pkg::TOTAL_BITS_DEF,
    parameter int RAPID_FEED = tlta_pkg::RAPID_FEED_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tlta_pt_if.sink                            pt,
    tlta_res_if.source                         res,
    input  logic                               cfg_we,
    input  logic [tlta_pkg::IDX_BITS-1:0]      cfg_index,
    input  logic [tlta_pkg::REG_BITS-1:0]      cfg_data
);
    logic [tlta_pkg::REG_BITS-1:0] cut_feed_reg, plunge_feed_reg;
    logic q_valid, q_pop, q_clear, q_move;
    logic [COORD_BITS-1:0] q_dx, q_dy, q_dz;
    logic [tlta_pkg::DEN_BITS-1:0] q_den;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_feed_reg    <= tlta_pkg::CUT_FEED_RST;
            plunge_feed_reg <= tlta_pkg::PLUNGE_FEED_RST;
        end
        else if (cfg_we)
        begin
            unique case (tlta_pkg::reg_idx_t'(cfg_index))
                tlta_pkg::REG_CUTTING_FEED: cut_feed_reg    <= cfg_data;
                tlta_pkg::REG_PLUNGE_FEED:  plunge_feed_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tlta_front #(.COORD_BITS(COORD_BITS), .RAPID_FEED(RAPID_FEED)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pt.valid), .in_ready(pt.ready),
        .first_point(pt.first_point),
        .px(pt.pos_x[COORD_BITS-1:0]), .py(pt.pos_y[COORD_BITS-1:0]),
        .pz(pt.pos_z[COORD_BITS-1:0]),
        .kind(pt.motion_kind), .ovr(pt.feed_override),
        .cut_feed(cut_feed_reg), .plunge_feed(plunge_feed_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_clear(q_clear), .q_move(q_move),
        .q_dx(q_dx), .q_dy(q_dy), .q_dz(q_dz), .q_den(q_den)
    );

    tlta_back #(.COORD_BITS(COORD_BITS), .TOTAL_BITS(TOTAL_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_clear(q_clear), .q_move(q_move),
        .q_dx(q_dx), .q_dy(q_dy), .q_dz(q_dz), .q_den(q_den),
        .out_valid(res.valid), .out_ready(res.ready),
        .seg_out(res.segment_length), .len_out(res.path_length),
        .time_out(res.path_time)
    );
endmodule

// ===== design/tlta_front.sv =====
// ----------------------------------------------------------------------------
// tlta_front
// classifies a point: deltas against previous point, feed denominator
// ----------------------------------------------------------------------------
module tlta_front #(
    parameter int COORD_BITS = tlta_pkg::COORD_BITS_DEF,
    parameter int RAPID_FEED = tlta_pkg::RAPID_FEED_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              first_point,
    input  logic [COORD_BITS-1:0]             px,
    input  logic [COORD_BITS-1:0]             py,
    input  logic [COORD_BITS-1:0]             pz,
    input  logic [tlta_pkg::KIND_BITS-1:0]    kind,
    input  logic [tlta_pkg::OVR_BITS-1:0]     ovr,
    input  logic [tlta_pkg::REG_BITS-1:0]     cut_feed,
    input  logic [tlta_pkg::REG_BITS-1:0]     plunge_feed,
    // queue entry
    output logic                              q_valid,
    input  logic                              q_pop,
    output logic                              q_clear,
    output logic                              q_move,
    output logic [COORD_BITS-1:0]             q_dx,
    output logic [COORD_BITS-1:0]             q_dy,
    output logic [COORD_BITS-1:0]             q_dz,
    output logic [tlta_pkg::DEN_BITS-1:0]     q_den
);
    localparam logic [tlta_pkg::DEN_BITS-1:0] RAPID_DEN =
        tlta_pkg::DEN_BITS'(64'(RAPID_FEED) * 64'd256);

    logic [COORD_BITS-1:0] last_x_reg, last_y_reg, last_z_reg;
    logic                  have_last_reg;
    logic                  q_valid_reg, q_clear_reg, q_move_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg, dz_reg;
    logic [tlta_pkg::DEN_BITS-1:0] den_reg, den_next;
    logic                  take;

    function automatic logic [COORD_BITS-1:0] absd(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b);
        logic signed [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        m = d[COORD_BITS] ? (~d + 1'b1) : d;
        return m[COORD_BITS-1:0];
    endfunction

    assign in_ready = !q_valid_reg;
    assign take = in_valid && in_ready;

    always_comb
    begin
        unique case (tlta_pkg::motion_kind_t'(kind))
            tlta_pkg::KIND_RAPID, tlta_pkg::KIND_MICROLIFT, tlta_pkg::KIND_RETRACT:
                den_next = RAPID_DEN;
            tlta_pkg::KIND_PLUNGE:
                den_next = {plunge_feed, 8'd0, {(tlta_pkg::DEN_BITS-35){1'b0}}} >>
                           (tlta_pkg::DEN_BITS - 35);
            default:
                den_next = tlta_pkg::DEN_BITS'(cut_feed) * tlta_pkg::DEN_BITS'(ovr);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_z_reg    <= '0;
            have_last_reg <= 1'b0;
            q_valid_reg   <= 1'b0;
            q_clear_reg   <= 1'b0;
            q_move_reg    <= 1'b0;
        end
        else
        begin
            if (q_pop)
                q_valid_reg <= 1'b0;
            if (take)
            begin
                q_valid_reg   <= 1'b1;
                q_clear_reg   <= first_point;
                q_move_reg    <= !first_point && have_last_reg;
                last_x_reg    <= px;
                last_y_reg    <= py;
                last_z_reg    <= pz;
                have_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dx_reg  <= absd(px, last_x_reg);
            dy_reg  <= absd(py, last_y_reg);
            dz_reg  <= absd(pz, last_z_reg);
            den_reg <= den_next;
        end
    end

    assign q_valid = q_valid_reg;
    assign q_clear = q_clear_reg;
    assign q_move  = q_move_reg;
    assign q_dx    = dx_reg;
    assign q_dy    = dy_reg;
    assign q_dz    = dz_reg;
    assign q_den   = den_reg;
endmodule

// ===== design/tlta_back.sv =====
// ----------------------------------------------------------------------------
// tlta_back
// squares, bitwise square root, scale multiply, restoring divide, totals
// ----------------------------------------------------------------------------
module tlta_back #(
    parameter int COORD_BITS = tlta_pkg::COORD_BITS_DEF,
    parameter int TOTAL_BITS = tlta_pkg::TOTAL_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  logic                              q_clear,
    input  logic                              q_move,
    input  logic [COORD_BITS-1:0]             q_dx,
    input  logic [COORD_BITS-1:0]             q_dy,
    input  logic [COORD_BITS-1:0]             q_dz,
    input  logic [tlta_pkg::DEN_BITS-1:0]     q_den,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tlta_pkg::SEG_BITS-1:0]     seg_out,
    output logic [tlta_pkg::OUT_BITS-1:0]     len_out,
    output logic [tlta_pkg::OUT_BITS-1:0]     time_out
);
    localparam int SQ_BITS = 2 * COORD_BITS + 2;
    localparam int CSQ_BITS = 2 * tlta_pkg::SEG_BITS;
    localparam int NB = tlta_pkg::NUM_BITS;
    localparam int DB = tlta_pkg::DEN_BITS;
    localparam int CNT_BITS = 7;
    localparam logic [TOTAL_BITS-1:0] TMAX = '1;

    tlta_pkg::back_state_t state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [1:0]            axis_reg;
    logic [SQ_BITS-1:0]    sum_reg;
    logic [tlta_pkg::SEG_BITS-1:0] root_reg;
    logic [NB-1:0]         num_reg;
    logic [DB:0]           rem_reg;
    logic [63:0]           quo_reg;
    logic                  qovf_reg;
    logic [TOTAL_BITS-1:0] len_reg, time_reg;
    logic [tlta_pkg::SEG_BITS-1:0] seg_reg;
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] d_sel;
    logic [2*COORD_BITS-1:0] d_sq;
    logic [tlta_pkg::SEG_BITS-1:0] cand;
    logic [CSQ_BITS-1:0]   cand_sq;
    logic [tlta_pkg::SEG_BITS-1:0] root_new;
    logic [DB:0]           rem_sh;
    logic                  quo_bit;
    logic [63:0]           quo_new;
    logic [64:0]           quo_sum;
    logic [TOTAL_BITS:0]   len_sum;

    always_comb
    begin
        case (axis_reg)
            2'd0:    d_sel = q_dx;
            2'd1:    d_sel = q_dy;
            default: d_sel = q_dz;
        endcase
    end
    assign d_sq     = d_sel * d_sel;
    assign cand     = root_reg | (tlta_pkg::SEG_BITS'(1) << cnt_reg[5:0]);
    assign cand_sq  = cand * cand;
    // root including the bit decided this cycle
    assign root_new = (cand_sq <= CSQ_BITS'(sum_reg)) ? cand : root_reg;
    assign rem_sh   = {rem_reg[DB-1:0], num_reg[NB-1]};
    assign quo_bit  = (rem_sh >= {1'b0, q_den});
    // quotient including the bit decided this cycle
    assign quo_new  = {quo_reg[62:0], quo_bit};
    assign len_sum  = {1'b0, len_reg} + (TOTAL_BITS+1)'(root_new);
    assign quo_sum  = {1'b0, quo_new} + 65'(time_reg);

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        unique case (state_reg)
            tlta_pkg::ST_IDLE:
                if (q_valid && !out_valid_reg)
                    state_next = q_move ? tlta_pkg::ST_SQ : tlta_pkg::ST_DONE;
            tlta_pkg::ST_SQ:
                if (axis_reg == 2'd2)
                    state_next = tlta_pkg::ST_SQRT;
            tlta_pkg::ST_SQRT:
                if (cnt_reg == '0)
                    state_next = (q_den == '0) ? tlta_pkg::ST_DONE : tlta_pkg::ST_MUL;
            tlta_pkg::ST_MUL:
                state_next = tlta_pkg::ST_DIV;
            tlta_pkg::ST_DIV:
                if (cnt_reg == '0)
                    state_next = tlta_pkg::ST_DONE;
            tlta_pkg::ST_DONE:
            begin
                q_pop = 1'b1;
                state_next = tlta_pkg::ST_IDLE;
            end
            default:
                state_next = tlta_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlta_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            time_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == tlta_pkg::ST_IDLE && q_valid && !out_valid_reg && q_clear)
            begin
                len_reg  <= '0;
                time_reg <= '0;
            end
            if (state_reg == tlta_pkg::ST_SQRT && cnt_reg == '0)
                len_reg <= len_sum[TOTAL_BITS] || len_sum[TOTAL_BITS-1:0] > TMAX
                           ? TMAX : len_sum[TOTAL_BITS-1:0];
            if (state_reg == tlta_pkg::ST_DIV && cnt_reg == '0)
            begin
                if (qovf_reg || quo_reg[63] || quo_sum > 65'(TMAX))
                    time_reg <= TMAX;
                else
                    time_reg <= quo_sum[TOTAL_BITS-1:0];
            end
            if (state_reg == tlta_pkg::ST_DONE)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tlta_pkg::ST_IDLE:
            begin
                axis_reg <= 2'd0;
                sum_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_BITS'(32);
            end
            tlta_pkg::ST_SQ:
            begin
                sum_reg  <= sum_reg + SQ_BITS'(d_sq);
                axis_reg <= axis_reg + 2'd1;
            end
            tlta_pkg::ST_SQRT:
            begin
                root_reg <= root_new;
                if (cnt_reg != '0)
                    cnt_reg <= cnt_reg - 1'b1;
            end
            tlta_pkg::ST_MUL:
            begin
                seg_reg  <= root_reg;
                num_reg  <= NB'(root_reg) * NB'(tlta_pkg::TIME_SCALE);
                rem_reg  <= '0;
                quo_reg  <= '0;
                qovf_reg <= 1'b0;
                cnt_reg  <= CNT_BITS'(NB - 1);
            end
            tlta_pkg::ST_DIV:
            begin
                num_reg  <= num_reg << 1;
                qovf_reg <= qovf_reg | quo_reg[63];
                quo_reg  <= quo_new;
                if (quo_bit)
                    rem_reg <= rem_sh - {1'b0, q_den};
                else
                    rem_reg <= rem_sh;
                if (cnt_reg != '0)
                    cnt_reg <= cnt_reg - 1'b1;
            end
            tlta_pkg::ST_DONE:
                seg_reg <= root_reg;
            default:
                ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign seg_out   = seg_reg;
    assign len_out   = tlta_pkg::OUT_BITS'(len_reg);
    assign time_out  = tlta_pkg::OUT_BITS'(time_reg);
endmodule

// ===== design/tlta_checker.sv =====
// ----------------------------------------------------------------------------
// tlta_checker
// port-level checks of the accumulator
// ----------------------------------------------------------------------------
module tlta_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [32:0] seg,
    input logic [47:0] plen
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(plen))
        else $error("result dropped while stalled");
    a_seg_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && plen != 48'hFFFFFFFFFFFF |-> 48'(seg) <= plen)
        else $error("segment exceeds path length");
    a_rst: assert property (@(posedge clk) !rst_n |=> !res_valid)
        else $error("result valid out of reset");
endmodule

bind toolpath_length_time_accumulator tlta_checker u_chk (
    .clk(clk), .rst_n(rst_n), .res_valid(res.valid), .res_ready(res.ready),
    .seg(res.segment_length), .plen(res.path_length)
);

// ===== tb/sv/toolpath_length_time_accumulator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toolpath_length_time_accumulator_tb
// self-checking bench for the toolpath length and time accumulator
// ----------------------------------------------------------------------------
// A table of directed points runs first, then random toolpaths in phases with
// different feed settings. Every accepted point is run through a bit-exact
// model of segment length, saturating path length and travel time, and each
// result transfer is compared field by field with the oldest expectation.
// Points come in bursts with random gaps and the result side stalls on its own,
// except in one random phase that runs with no idling on either side.
module toolpath_length_time_accumulator_tb;
    import tlta_pkg::*;

    typedef struct {
        logic               first_point;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        motion_kind_t       kind;
        logic [15:0]        feed_override;
    } point_t;

    typedef struct {
        logic [SEG_BITS-1:0] seg;
        logic [OUT_BITS-1:0] len;
        logic [OUT_BITS-1:0] tim;
    } totals_t;

    // one row of the directed table; known is set where the result is typed in
    typedef struct {
        point_t  pt;
        logic    known;
        totals_t want;
    } row_t;

    localparam logic [63:0] TOTAL_MAX = 64'hFFFF_FFFF_FFFF;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_POINTS = 370;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_BITS-1:0] cfg_index;
    logic [REG_BITS-1:0] cfg_data;

    tlta_pt_if  pt_ch ();
    tlta_res_if res_ch ();

    toolpath_length_time_accumulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt        (pt_ch.sink),
        .res       (res_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state: feeds, previous position and running totals
    logic [REG_BITS-1:0] cut_feed;
    logic [REG_BITS-1:0] plunge_feed;
    logic signed [31:0]  prev_x, prev_y, prev_z;
    logic                prev_valid;
    logic [63:0]         len_sum;
    logic [63:0]         time_sum;

    totals_t pending_totals[$];
    int      mismatches;

    // sender pacing
    int  burst_left;
    bit  no_gaps;
    // receiver stall pattern
    int  stall_left;
    int  run_left;
    bit  no_stalls;

    // stimulus-side copy of the last position, for random walks
    logic signed [31:0] walk_x, walk_y, walk_z;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [63:0] sat_total(logic [63:0] sum, logic [63:0] add);
        logic [65:0] s;
        s = 66'(sum) + 66'(add);
        return (s > 66'(TOTAL_MAX)) ? TOTAL_MAX : s[63:0];
    endfunction

    // advance the model by one point and return the result it produces
    function automatic totals_t track_point(point_t p);
        totals_t     r;
        longint      d[3];
        logic [131:0] sq, cand;
        logic [32:0] root;
        logic [63:0] den;
        logic [127:0] quot;
        r.seg = '0;
        if (p.first_point)
        begin
            len_sum = '0;
            time_sum = '0;
        end
        else if (prev_valid)
        begin
            d[0] = longint'(p.pos_x) - longint'(prev_x);
            d[1] = longint'(p.pos_y) - longint'(prev_y);
            d[2] = longint'(p.pos_z) - longint'(prev_z);
            sq = '0;
            for (int i = 0; i < 3; i++)
            begin
                if (d[i] < 0)
                    d[i] = -d[i];
                sq = sq + 132'(d[i]) * 132'(d[i]);
            end
            // bitwise floor square root
            root = '0;
            for (int b = 32; b >= 0; b--)
            begin
                cand = 132'(root | (33'd1 << b));
                if (cand * cand <= sq)
                    root = cand[32:0];
            end
            r.seg = root;
            len_sum = sat_total(len_sum, 64'(root));
            case (p.kind)
                KIND_RAPID, KIND_MICROLIFT, KIND_RETRACT:
                    den = 64'(RAPID_FEED_DEF) * 64'd256;
                KIND_PLUNGE:
                    den = 64'(plunge_feed) * 64'd256;
                default:
                    den = 64'(cut_feed) * 64'(p.feed_override);
            endcase
            // zero feed moves add length but no time
            if (den != 0)
            begin
                quot = (128'(root) * 128'(TIME_SCALE)) / 128'(den);
                if (quot[127:64] != 0)
                    quot = 128'(64'hFFFF_FFFF_FFFF_FFFF);
                time_sum = sat_total(time_sum, quot[63:0]);
            end
        end
        prev_x = p.pos_x;
        prev_y = p.pos_y;
        prev_z = p.pos_z;
        prev_valid = 1'b1;
        r.len = len_sum[OUT_BITS-1:0];
        r.tim = time_sum[OUT_BITS-1:0];
        return r;
    endfunction

    // drive one point until its transfer, then queue the expected result
    task automatic send_point(point_t p, logic known, totals_t want);
        totals_t got;
        int gap;
        pt_ch.valid <= 1'b1;
        pt_ch.first_point <= p.first_point;
        pt_ch.pos_x <= p.pos_x;
        pt_ch.pos_y <= p.pos_y;
        pt_ch.pos_z <= p.pos_z;
        pt_ch.motion_kind <= p.kind;
        pt_ch.feed_override <= p.feed_override;
        do
            @(posedge clk);
        while (!pt_ch.ready);
        got = track_point(p);
        pending_totals.push_back(known ? want : got);
        walk_x = p.pos_x;
        walk_y = p.pos_y;
        walk_z = p.pos_z;
        // burst / gap pacing
        if (!no_gaps)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 15);
                gap = $urandom_range(1, 8);
                pt_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // let every queued result arrive, then idle with the point channel low
    task automatic drain_results();
        pt_ch.valid <= 1'b0;
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [REG_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CUTTING_FEED)
            cut_feed = value;
        else
            plunge_feed = value;
    endtask

    function automatic point_t mk_point(logic first, longint x, longint y, longint z,
                                        motion_kind_t kind, logic [15:0] ovr);
        point_t p;
        p.first_point = first;
        p.pos_x = x[31:0];
        p.pos_y = y[31:0];
        p.pos_z = z[31:0];
        p.kind = kind;
        p.feed_override = ovr;
        return p;
    endfunction

    function automatic logic signed [31:0] next_coord(logic signed [31:0] last, int mode);
        case (mode)
            0: return last + $signed(32'($urandom_range(0, 4000)) - 32'sd2000);
            1: return $signed($urandom());
            2: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return last;
        endcase
    endfunction

    function automatic point_t random_point();
        point_t p;
        int r, mode;
        r = $urandom_range(0, 99);
        // mostly short walks, some wild jumps to extreme or random positions
        mode = (r < 72) ? 0 : (r < 87) ? 1 : (r < 95) ? 2 : 3;
        p.first_point = ($urandom_range(0, 99) < 3);
        p.pos_x = next_coord(walk_x, mode);
        p.pos_y = next_coord(walk_y, mode);
        p.pos_z = next_coord(walk_z, mode);
        p.kind = motion_kind_t'($urandom_range(0, 7));
        r = $urandom_range(0, 9);
        if (r < 3)
            p.feed_override = 16'd256;
        else if (r == 3)
            p.feed_override = 16'd0;
        else if (r == 4)
            p.feed_override = 16'($urandom_range(1, 8));
        else
            p.feed_override = 16'($urandom());
        return p;
    endfunction

    // receiver: runs of ready broken by random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= 0;
            run_left <= 0;
        end
        else if (no_stalls)
            res_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (run_left > 0)
        begin
            res_ch.ready <= 1'b1;
            run_left <= run_left - 1;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            run_left <= $urandom_range(0, 12);
            stall_left <= $urandom_range(0, 6);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_totals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: seg %0d len %0d time %0d",
                             res_ch.segment_length, res_ch.path_length, res_ch.path_time);
            end
            else
            begin
                totals_t want;
                want = pending_totals.pop_front();
                if (res_ch.segment_length !== want.seg || res_ch.path_length !== want.len
                    || res_ch.path_time !== want.tim)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: seg %0d/%0d len %0d/%0d time %0d/%0d (exp/act)",
                                 want.seg, res_ch.segment_length, want.len,
                                 res_ch.path_length, want.tim, res_ch.path_time);
                end
            end
        end
    end

    row_t rows[$];
    totals_t no_want;

    initial
    begin
        mismatches = 0;
        burst_left = 0;
        no_gaps = 1'b0;
        no_stalls = 1'b0;
        walk_x = '0;
        walk_y = '0;
        walk_z = '0;
        cut_feed = CUT_FEED_RST;
        plunge_feed = PLUNGE_FEED_RST;
        prev_x = '0;
        prev_y = '0;
        prev_z = '0;
        prev_valid = 1'b0;
        len_sum = '0;
        time_sum = '0;
        no_want = '{seg: '0, len: '0, tim: '0};

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_CUTTING_FEED;
        cfg_data <= '0;
        pt_ch.valid <= 1'b0;
        pt_ch.first_point <= 1'b0;
        pt_ch.pos_x <= '0;
        pt_ch.pos_y <= '0;
        pt_ch.pos_z <= '0;
        pt_ch.motion_kind <= KIND_RAPID;
        pt_ch.feed_override <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset feeds: cutting 1 m/min, plunge 0.3 m/min
        // a point with no previous point and no first flag keeps zero totals
        rows.push_back('{mk_point(0, 0, 0, 0, KIND_LINEAR, 256), 1, '{0, 0, 0}});
        // 3-4-5 cut at 1.0 override: 5 um at 1e6 um/min is 300 us
        rows.push_back('{mk_point(0, 3, 4, 0, KIND_LINEAR, 256), 1, '{5, 5, 300}});
        // rapid back at 1e7 um/min: 30 us
        rows.push_back('{mk_point(0, 0, 0, 0, KIND_RAPID, 256), 1, '{5, 10, 330}});
        // plunge 12 um, override ignored: 2400 us
        rows.push_back('{mk_point(0, 0, 0, 12, KIND_PLUNGE, 0), 1, '{12, 22, 2730}});
        // zero-length arc adds nothing
        rows.push_back('{mk_point(0, 0, 0, 12, KIND_ARC_CW, 256), 1, '{0, 22, 2730}});
        // zero override: length only
        rows.push_back('{mk_point(0, 0, 0, 0, KIND_LINEAR, 0), 1, '{12, 34, 2730}});
        // new path at the negative corner clears totals
        rows.push_back('{mk_point(1, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                                  KIND_OTHER, 16'hFFFF), 1, '{0, 0, 0}});
        // full diagonal moves across the coordinate range, every motion kind
        rows.push_back('{mk_point(0, 2147483647, 2147483647, 2147483647, KIND_LINEAR, 1),
                         0, no_want});
        rows.push_back('{mk_point(0, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                                  KIND_MICROLIFT, 256), 0, no_want});
        rows.push_back('{mk_point(0, 2147483647, -64'sd2147483648, 0, KIND_RETRACT, 256),
                         0, no_want});
        rows.push_back('{mk_point(0, -64'sd2147483648, 2147483647, 2147483647,
                                  KIND_ARC_CCW, 16'hFFFF), 0, no_want});
        rows.push_back('{mk_point(0, 0, 0, 0, KIND_OTHER, 16'h8000), 0, no_want});
        rows.push_back('{mk_point(0, 1, -1, 1, KIND_ARC_CW, 16'h00FF), 0, no_want});
        rows.push_back('{mk_point(0, 1000, 2000, -3000, KIND_PLUNGE, 256), 0, no_want});
        rows.push_back('{mk_point(1, 5, 5, 5, KIND_RAPID, 256), 1, '{0, 0, 0}});
        rows.push_back('{mk_point(0, 2147483647, 2147483647, 2147483647, KIND_LINEAR,
                                  16'h5555), 0, no_want});
        rows.push_back('{mk_point(0, 0, 0, 0, KIND_LINEAR, 16'hAAAA), 0, no_want});
        foreach (rows[i])
            send_point(rows[i].pt, rows[i].known, rows[i].want);
        drain_results();

        // random toolpaths, one feed setting per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_CUTTING_FEED, 27'd1);
                    write_reg(REG_PLUNGE_FEED, 27'd0);
                end
                1:
                begin
                    write_reg(REG_CUTTING_FEED, 27'd100000000);
                    write_reg(REG_PLUNGE_FEED, 27'd100000000);
                end
                2:
                begin
                    write_reg(REG_CUTTING_FEED, 27'd0);
                    write_reg(REG_PLUNGE_FEED, 27'd1);
                end
                3:
                begin
                    write_reg(REG_CUTTING_FEED, 27'($urandom_range(1, 100000000)));
                    write_reg(REG_PLUNGE_FEED, 27'($urandom_range(1, 100000000)));
                end
                default:
                begin
                    write_reg(REG_CUTTING_FEED, 27'd1000000);
                    write_reg(REG_PLUNGE_FEED, 27'd300000);
                end
            endcase
            // one phase runs with no idling on either side
            no_gaps = (ph == 1);
            no_stalls = (ph == 1);
            for (int n = 0; n < PHASE_POINTS; n++)
                send_point(random_point(), 1'b0, no_want);
            drain_results();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/tlta_pkg.sv
design/tlta_if.sv
design/tlta_front.sv
design/tlta_back.sv
design/toolpath_length_time_accumulator.sv
design/tlta_checker.sv
tb/sv/toolpath_length_time_accumulator_tb.sv
